[sv/windowed_iir_smoother_defines.svh]
// Assertion macros for the windowed IIR smoother.
// Included by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef WINDOWED_IIR_SMOOTHER_DEFINES_SVH
`define WINDOWED_IIR_SMOOTHER_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define WIS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define WIS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wis_pkg.sv]
// Shared constants and types for the windowed IIR smoother.
// No dependencies; used by wis_mul and windowed_iir_smoother.
`timescale 1ns / 1ps

package wis_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;

    localparam int SAMPLE_W = 32;          // signed Q24.8
    localparam int COEF_W   = 16;          // unsigned Q0.16
    localparam int HELD_W   = 5;
    localparam int FRAC_X   = 16;          // extra accumulator fraction bits
    localparam int ACC_W    = SAMPLE_W + FRAC_X;
    localparam int SUM_W    = ACC_W + COEF_W;
    localparam int HALF_W   = ACC_W / 2;   // accumulator split for the multiplier

    localparam int MCAND_W  = COEF_W + 1;  // holds 1 - a, which may be exactly one
    localparam int MPLIER_W = SAMPLE_W;
    localparam int PROD_W   = MCAND_W + MPLIER_W;

    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [COEF_W-1:0]   COEF_RESET = 16'd9830;
    localparam logic [SAMPLE_W-1:0] SIGN_FLIP  = 32'h8000_0000;
    localparam logic [FRAC_X-1:0]   HALF_LSB   = 16'h8000;

    localparam logic [ADDR_W-3:0]   REG_SMOOTHING = 1'b0;

    typedef struct packed {
        logic                en;
        logic [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0] mplier;
    } t_mul_req;

endpackage

[sv/wis_mul.sv]
// Shared unsigned multiplier with a registered product.
// Depends on wis_pkg for operand widths and the request struct.
`timescale 1ns / 1ps

module wis_mul (
    input  logic                         i_clk,
    input  wis_pkg::t_mul_req            i_req,
    output logic [wis_pkg::PROD_W-1:0]   o_prod
);

    logic [wis_pkg::PROD_W-1:0] r_prod;
    logic [wis_pkg::PROD_W-1:0] n_prod;

    assign n_prod = {{wis_pkg::MPLIER_W{1'b0}}, i_req.mcand} *
                    {{wis_pkg::MCAND_W{1'b0}}, i_req.mplier};

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

[sv/windowed_iir_smoother.sv]
// Windowed first-order IIR smoother: sample ring, sequencer and accumulator.
// Depends on wis_pkg, wis_mul and windowed_iir_smoother_defines.svh.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+----------------------------------
//   in       | i_in_valid / o_in_stall       | i_sample_value
//   out      | o_out_valid / i_out_stall     | o_filtered_value, o_samples_held
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// After an item with n samples held is accepted, the block runs a ring read, a load, one
// filter step for each of the n-1 older samples (three products through the one shared
// multiplier plus a fold) and rounding, then returns to idle; it takes no new sample
// before then. Reset clears the pointers and fill count and sets the coefficient to its
// reset value; the ring holds nothing meaningful until written.
// A finished item waits in the output register; while it is held, rounding stalls.
`timescale 1ns / 1ps
`include "windowed_iir_smoother_defines.svh"

module windowed_iir_smoother #(
    parameter int WINDOW_DEPTH = wis_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [wis_pkg::SAMPLE_W-1:0]  i_sample_value,

    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [wis_pkg::SAMPLE_W-1:0]  o_filtered_value,
    output logic [wis_pkg::HELD_W-1:0]           o_samples_held,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wis_pkg::ADDR_W-1:0]           paddr,
    input  logic [wis_pkg::DATA_W-1:0]           pwdata,
    output logic [wis_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL     = CNT_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_INIT,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_ROUND
    } t_state;

    t_state                           r_state, n_state;
    logic [PTR_W-1:0]                 r_wr_pos, n_wr_pos;
    logic [CNT_W-1:0]                 r_fill, n_fill;
    logic [PTR_W-1:0]                 r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic [wis_pkg::ACC_W-1:0]        r_acc, n_acc;
    logic [wis_pkg::SUM_W-1:0]        r_sum, n_sum;
    logic [wis_pkg::COEF_W-1:0]       r_coef, n_coef;
    logic                             r_out_valid, n_out_valid;
    logic [wis_pkg::SAMPLE_W-1:0]     r_out_value, n_out_value;
    logic [wis_pkg::HELD_W-1:0]       r_out_held, n_out_held;

    logic [wis_pkg::SAMPLE_W-1:0]     r_ring [WINDOW_DEPTH];
    logic [wis_pkg::SAMPLE_W-1:0]     r_mem_q;
    logic                             rd_en;
    logic                             wr_en;

    wis_pkg::t_mul_req                mul_req;
    logic [wis_pkg::PROD_W-1:0]       prod;
    logic [wis_pkg::MCAND_W-1:0]      coef_b;
    logic [wis_pkg::ACC_W:0]          rounded;
    logic [CNT_W+wis_pkg::HELD_W-1:0] fill_ext;
    logic [PTR_W-1:0]                 wr_pos_inc;
    logic [PTR_W-1:0]                 rd_ptr_inc;
    logic                             in_acc;
    logic                             out_acc;
    logic                             cfg_wr;
    logic                             sel_smoothing;

    function automatic logic [wis_pkg::ACC_W-1:0] SUM_SHIFT(
        input logic [wis_pkg::SUM_W-1:0] sum
    );
        SUM_SHIFT = sum[wis_pkg::SUM_W-1:wis_pkg::FRAC_X];
    endfunction

    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign out_acc = r_out_valid && !i_out_stall;

    assign sel_smoothing = (paddr[wis_pkg::ADDR_W-1:2] == wis_pkg::REG_SMOOTHING);
    assign cfg_wr        = psel && penable && pwrite && sel_smoothing;

    // weight on the new sample: one minus a, in Q0.16 with room for exactly one
    assign coef_b = {1'b1, {wis_pkg::COEF_W{1'b0}}} - {1'b0, r_coef};

    assign wr_pos_inc = (r_wr_pos == LAST_POS) ? '0 : r_wr_pos + 1'b1;
    assign rd_ptr_inc = (r_rd_ptr == LAST_POS) ? '0 : r_rd_ptr + 1'b1;
    assign rounded    = {1'b0, r_acc} + {{(wis_pkg::ACC_W+1-wis_pkg::FRAC_X){1'b0}},
                                         wis_pkg::HALF_LSB};
    assign fill_ext   = {{wis_pkg::HELD_W{1'b0}}, r_fill};
    assign wr_en      = in_acc;

    always_comb begin
        mul_req = '0;
        case (r_state)
            S_P0: begin
                mul_req.en     = 1'b1;
                mul_req.mcand  = coef_b;
                mul_req.mplier = r_mem_q ^ wis_pkg::SIGN_FLIP;
            end
            S_P1: begin
                mul_req.en     = 1'b1;
                mul_req.mcand  = {1'b0, r_coef};
                mul_req.mplier = {{(wis_pkg::MPLIER_W-wis_pkg::HALF_W){1'b0}},
                                  r_acc[wis_pkg::HALF_W-1:0]};
            end
            S_P2: begin
                mul_req.en     = 1'b1;
                mul_req.mcand  = {1'b0, r_coef};
                mul_req.mplier = {{(wis_pkg::MPLIER_W-wis_pkg::HALF_W){1'b0}},
                                  r_acc[wis_pkg::ACC_W-1:wis_pkg::HALF_W]};
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    wis_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    always_comb begin
        n_state     = r_state;
        n_wr_pos    = r_wr_pos;
        n_fill      = r_fill;
        n_rd_ptr    = r_rd_ptr;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_coef      = r_coef;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;
        n_out_value = r_out_value;
        n_out_held  = r_out_held;
        rd_en       = 1'b0;

        if (cfg_wr) begin
            n_coef = pwdata[wis_pkg::COEF_W-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_wr_pos = wr_pos_inc;
                    if (r_fill == FULL) begin
                        n_rd_ptr = wr_pos_inc;   // oldest entry sits after the newest
                        n_cnt    = FULL - CNT_ONE;
                    end else begin
                        n_fill   = r_fill + CNT_ONE;
                        n_rd_ptr = '0;
                        n_cnt    = r_fill;
                    end
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                rd_en    = 1'b1;
                n_rd_ptr = rd_ptr_inc;
                n_state  = S_INIT;
            end
            S_INIT: begin
                n_acc = {r_mem_q ^ wis_pkg::SIGN_FLIP, {wis_pkg::FRAC_X{1'b0}}};
                if (r_cnt == '0) begin
                    n_state = S_ROUND;
                end else begin
                    rd_en    = 1'b1;
                    n_rd_ptr = rd_ptr_inc;
                    n_state  = S_P0;
                end
            end
            S_P0: begin
                n_state = S_P1;
            end
            S_P1: begin
                // b*x scaled up by 2^16, plus the rounding half
                n_sum   = {prod[wis_pkg::ACC_W-1:0], wis_pkg::HALF_LSB};
                n_state = S_P2;
            end
            S_P2: begin
                n_sum   = r_sum + {{(wis_pkg::SUM_W-wis_pkg::PROD_W){1'b0}}, prod};
                n_state = S_P3;
            end
            S_P3: begin
                n_acc = SUM_SHIFT(r_sum + {prod[wis_pkg::SUM_W-wis_pkg::HALF_W-1:0],
                                           {wis_pkg::HALF_W{1'b0}}});
                n_cnt = r_cnt - CNT_ONE;
                if (r_cnt == CNT_ONE) begin
                    n_state = S_ROUND;
                end else begin
                    rd_en    = 1'b1;
                    n_rd_ptr = rd_ptr_inc;
                    n_state  = S_P0;
                end
            end
            S_ROUND: begin
                if (!r_out_valid || out_acc) begin
                    n_out_valid = 1'b1;
                    n_out_value = rounded[wis_pkg::ACC_W-1:wis_pkg::FRAC_X] ^
                                  wis_pkg::SIGN_FLIP;
                    n_out_held  = fill_ext[wis_pkg::HELD_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_rd_ptr    <= '0;
            r_cnt       <= '0;
            r_coef      <= wis_pkg::COEF_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_pos    <= n_wr_pos;
            r_fill      <= n_fill;
            r_rd_ptr    <= n_rd_ptr;
            r_cnt       <= n_cnt;
            r_coef      <= n_coef;
            r_out_valid <= n_out_valid;
        end
        r_acc       <= n_acc;
        r_sum       <= n_sum;
        r_out_value <= n_out_value;
        r_out_held  <= n_out_held;
    end

    // sample ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_wr_pos] <= i_sample_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mem_q <= r_ring[r_rd_ptr];
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_samples_held   = r_out_held;
    assign pready           = 1'b1;
    assign prdata           = sel_smoothing ?
                              {{(wis_pkg::DATA_W-wis_pkg::COEF_W){1'b0}}, r_coef} : '0;

    `WIS_ASSERT_NEXT(a_busy_after_accept, in_acc, o_in_stall, "input taken while busy")
    `WIS_ASSERT_ALWAYS(a_fill_bound, r_fill <= FULL, "fill count past window depth")
    `WIS_ASSERT_IMPL(a_step_count, r_state == S_P0, r_cnt != '0, "filter step with no sample")
    `WIS_ASSERT_IMPL(a_result_held, r_out_valid, r_fill != '0, "result with empty window")
    `WIS_ASSERT_IMPL(a_result_src, $rose(r_out_valid), $past(r_state == S_ROUND), "result loaded outside rounding")

endmodule

[tb/windowed_iir_smoother_tb.sv]
// Self-checking testbench for windowed_iir_smoother: a window tracker predicts each filtered
// value; tasks drive the sample and APB ports and a process stalls the result side, with random idling on both sides.
// Depends on wis_pkg and the windowed_iir_smoother RTL.
`timescale 1ns / 1ps

module windowed_iir_smoother_tb;

    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_ITEMS   = 120;   // final stretch runs with no idling
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 80;    // outlasts one full-window item
    localparam logic [wis_pkg::ADDR_W-1:0] COEF_ADDR = {wis_pkg::REG_SMOOTHING, 2'b00};

    localparam logic [wis_pkg::SAMPLE_W-1:0] EDGE_SAMPLES [5] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001
    };
    localparam logic [wis_pkg::SAMPLE_W-1:0] DIRECTED_SAMPLES [18] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
        32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0080, 32'hFFFF_FF80, 32'h0000_5A00,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678,
        32'hEDCB_A988, 32'h0000_0100, 32'h7FFF_FFFF
    };

    typedef struct {
        logic [wis_pkg::SAMPLE_W-1:0] filtered;
        logic [wis_pkg::HELD_W-1:0]   held;
    } t_smoothed;

    // Mirror of the sample window; computes the smoothed value for each accepted item.
    class window_tracker;
        logic [wis_pkg::SAMPLE_W-1:0] ring [wis_pkg::WINDOW_DEPTH_DEF];
        int                           wr_pos;
        int                           held;
        logic [wis_pkg::COEF_W-1:0]   coefficient;
        t_smoothed                    expected_q [$];
        int                           mismatches;

        function new();
            wr_pos      = 0;
            held        = 0;
            coefficient = wis_pkg::COEF_RESET;
            mismatches  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_sample(logic [wis_pkg::SAMPLE_W-1:0] sample);
            logic [79:0]              acc;
            logic [wis_pkg::COEF_W:0] rest;
            int                       idx;
            t_smoothed                r;
            ring[wr_pos] = sample;
            wr_pos = (wr_pos + 1) % wis_pkg::WINDOW_DEPTH_DEF;
            if (held < wis_pkg::WINDOW_DEPTH_DEF) held++;
            rest = 17'h1_0000 - {1'b0, coefficient};
            idx  = (wr_pos + wis_pkg::WINDOW_DEPTH_DEF - held) % wis_pkg::WINDOW_DEPTH_DEF;
            // offset binary keeps every term unsigned; floor division matches the block
            acc = {32'b0, ring[idx] ^ wis_pkg::SIGN_FLIP, 16'b0};
            for (int k = 1; k < held; k++) begin
                idx = (idx + 1) % wis_pkg::WINDOW_DEPTH_DEF;
                acc = (coefficient * acc
                       + rest * {32'b0, ring[idx] ^ wis_pkg::SIGN_FLIP, 16'b0}
                       + 80'(wis_pkg::HALF_LSB)) >> wis_pkg::FRAC_X;
            end
            acc = (acc + 80'(wis_pkg::HALF_LSB)) >> wis_pkg::FRAC_X;
            r.filtered = acc[31:0] ^ wis_pkg::SIGN_FLIP;
            r.held     = held[wis_pkg::HELD_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_output(logic [wis_pkg::SAMPLE_W-1:0] filtered,
                                   logic [wis_pkg::HELD_W-1:0] held_now);
            t_smoothed r;
            if (expected_q.size() == 0) begin
                $error("unexpected result: filtered_value %0d samples_held %0d",
                       $signed(filtered), held_now);
                mismatches++;
                return;
            end
            r = expected_q.pop_front();
            if (filtered !== r.filtered) begin
                $error("filtered_value: expected %0d, got %0d",
                       $signed(r.filtered), $signed(filtered));
                mismatches++;
            end
            if (held_now !== r.held) begin
                $error("samples_held: expected %0d, got %0d", r.held, held_now);
                mismatches++;
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic signed [wis_pkg::SAMPLE_W-1:0] i_sample_value = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic signed [wis_pkg::SAMPLE_W-1:0] o_filtered_value;
    logic [wis_pkg::HELD_W-1:0]          o_samples_held;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [wis_pkg::ADDR_W-1:0]          paddr = '0;
    logic [wis_pkg::DATA_W-1:0]          pwdata = '0;
    logic [wis_pkg::DATA_W-1:0]          prdata;
    logic                                pready;

    window_tracker                       tracker;
    logic [wis_pkg::SAMPLE_W-1:0]        walk_pos = '0;
    bit                                  no_idle = 1'b0;
    bit                                  hold_req = 1'b0;
    int                                  readback_errors = 0;

    windowed_iir_smoother u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample_value   (i_sample_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_filtered_value (o_filtered_value),
        .o_samples_held   (o_samples_held),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** windowed_iir_smoother: FAILED **");
        $finish;
    end

    // Both channels are sampled here, before any update at this edge lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                tracker.check_output(o_filtered_value, o_samples_held);
            if (i_in_valid && !o_in_stall)
                tracker.push_sample(i_sample_value);
        end
    end

    // Result side: random stall bursts, plus one long hold-off to back the block up.
    initial begin
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [wis_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return EDGE_SAMPLES[$urandom_range(0, 4)];
            2: return $urandom_range(0, 2048) - 1024;
            default: begin
                // slowly drifting angle
                walk_pos = walk_pos + $urandom_range(0, 4000) - 2000;
                return walk_pos;
            end
        endcase
    endfunction

    function automatic logic [wis_pkg::DATA_W-1:0] pick_coefficient();
        logic [wis_pkg::DATA_W-1:0] value;
        value = $urandom;   // upper bits are junk the register must drop
        case ($urandom_range(0, 6))
            0: value[15:0] = 16'd0;
            1: value[15:0] = 16'hFFFF;
            2: value[15:0] = 16'd1;
            3: value[15:0] = 16'hFFFE;
            4: value[15:0] = 16'h8000;
            default: value[15:0] = 16'($urandom_range(0, 65535));
        endcase
        return value;
    endfunction

    task automatic send_sample(input logic [wis_pkg::SAMPLE_W-1:0] value);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        // the last item's push has surely landed by the next edge
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic read_coef();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= COEF_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {16'b0, tracker.coefficient}) begin
            $error("smoothing_coefficient: expected %0d, got %0d", tracker.coefficient, prdata);
            readback_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_coef(input logic [wis_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COEF_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.coefficient = value[wis_pkg::COEF_W-1:0];
        read_coef();
    endtask

    initial begin
        int sent;
        int phase_len;
        tracker = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficient, window filling from one sample through wrap-around
        read_coef();
        foreach (DIRECTED_SAMPLES[k]) send_sample(DIRECTED_SAMPLES[k]);
        wait_drain();
        // no smoothing: result is the newest sample
        write_coef(32'hDEAD_0000);
        foreach (EDGE_SAMPLES[k]) send_sample(EDGE_SAMPLES[k]);
        wait_drain();
        // heaviest smoothing: output clings to the oldest sample
        write_coef(32'h0000_FFFF);
        foreach (EDGE_SAMPLES[k]) send_sample(EDGE_SAMPLES[4 - k]);
        wait_drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_coef(pick_coefficient());
            no_idle = (sent >= RANDOM_ITEMS - CALM_ITEMS);
            if (sent == 0) hold_req = 1'b1;
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) begin
                send_sample(pick_sample());
                sent++;
            end
            wait_drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && readback_errors == 0 && tracker.pending() == 0) begin
            $display("** windowed_iir_smoother: PASSED **");
        end else begin
            $display("** windowed_iir_smoother: FAILED **");
        end
        $finish;
    end

endmodule
